// ----- rtl/core/tcf_pkg.sv -----
// Shared constants and types for the termcap cursor formatter.
package tcf_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_GT    = 8'h3e;

	localparam int BIN_W = 17;
	localparam int NDIG  = 5;
	localparam int BCD_W = 4 * NDIG;
	localparam logic [BIN_W-1:0] DEC_MAX = 17'd99999;

	localparam int ADD_W = 10;
	localparam logic [ADD_W-1:0] ADD_MAX = 10'd1023;

	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] M_NORMAL = 3'd0;
	localparam logic [MODE_W-1:0] M_PCT    = 3'd1;
	localparam logic [MODE_W-1:0] M_PLUS   = 3'd2;
	localparam logic [MODE_W-1:0] M_GTX    = 3'd3;
	localparam logic [MODE_W-1:0] M_GTY    = 3'd4;
	localparam logic [MODE_W-1:0] M_DONE   = 3'd5;

	typedef struct packed {
		logic [7:0] data;
		logic       bv;
		logic       eos;
	} tcf_word_t;

endpackage

// ----- rtl/core/tcf_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module tcf_bcd (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tcf_pkg::BIN_W-1:0]  bin,
	output logic                       done,
	output logic [tcf_pkg::BCD_W-1:0]  bcd
);

	localparam int CNT_W = $clog2(tcf_pkg::BIN_W + 1);

	logic [tcf_pkg::BIN_W-1:0] bin_q;
	logic [tcf_pkg::BCD_W-1:0] bcd_q;
	logic [tcf_pkg::BCD_W-1:0] adj;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	always_comb begin
		for (int i = 0; i < tcf_pkg::NDIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(tcf_pkg::BIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[tcf_pkg::BCD_W-2:0], bin_q[tcf_pkg::BIN_W-1]};
			bin_q <= {bin_q[tcf_pkg::BIN_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- rtl/core/tcf_oreg.sv -----
// Output word register between the formatter and the downstream channel.
module tcf_oreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  tcf_pkg::tcf_word_t   push_word,
	output logic                 push_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 end_of_string
);

	logic               valid_q;
	tcf_pkg::tcf_word_t word_q;

	assign push_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			word_q <= push_word;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = word_q.data;
	assign byte_valid    = word_q.bv;
	assign end_of_string = word_q.eos;

endmodule

// ----- rtl/core/termcap_cursor_formatter_core.sv -----
// Flow: a plain byte is registered in the hold word, then passed to the output register.
// Decimal codes go through the clamp, bit-serial BCD conversion and setup states,
// then one digit word per cycle while the output register accepts.
// A new input byte is taken only in idle, once the last one's output has been pushed;
// the 17-bit serial converter sets the decimal rate. Codes with no output, unless last, stay idle.
// Reset (arst_n low) clears the parse state, arguments and output valid at once.
module termcap_cursor_formatter_core #(
	parameter int OUT_LIMIT = 31,
	parameter int ARG_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         cap_byte,
	input  logic               first,
	input  logic               last,
	input  logic signed [15:0] column,
	input  logic signed [15:0] row_arg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               end_of_string
);

	localparam int AW   = ARG_BITS + 2;
	localparam int XW   = (AW > 16) ? AW : 16;
	localparam int SW   = AW + 1;
	localparam int CMPW = (SW > tcf_pkg::BIN_W) ? SW : tcf_pkg::BIN_W + 1;
	localparam int CW   = $clog2(OUT_LIMIT + 1);
	localparam logic signed [AW-1:0] ARG_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [XW-1:0] ARG_HI  = {{(XW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [XW-1:0] ARG_LO  = ~ARG_HI;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EMIT  = 3'd1;
	localparam logic [2:0] S_CLAMP = 3'd2;
	localparam logic [2:0] S_CONV  = 3'd3;
	localparam logic [2:0] S_PREP  = 3'd4;
	localparam logic [2:0] S_DIG   = 3'd5;

	function automatic logic signed [AW-1:0] load_arg(input logic signed [15:0] x);
		logic signed [XW-1:0] xe;
		xe = XW'(x);
		if (xe > ARG_HI) begin
			return ARG_MAX;
		end else if (xe < ARG_LO) begin
			return ~ARG_MAX;
		end else begin
			return AW'(xe);
		end
	endfunction

	logic [2:0]                state_q;
	logic [tcf_pkg::MODE_W-1:0] mode_q;
	logic signed [AW-1:0]      arg0_q, arg1_q;
	logic [1:0]                ptr_q;
	logic [tcf_pkg::ADD_W-1:0] pend_q;
	logic [7:0]                thr_q;
	logic [CW-1:0]             cnt_q;
	logic                      last_q;
	logic [2:0]                wid_q;
	logic signed [SW-1:0]      sum_q;
	tcf_pkg::tcf_word_t        hold_q;
	logic [2:0]                dig_idx_q, dig_left_q;

	// current state as seen by this byte: a first byte restarts the string
	logic [tcf_pkg::MODE_W-1:0] e_mode, n_mode;
	logic signed [AW-1:0]      e_a0, e_a1, n_a0, n_a1, cur, a0_inc, a1_inc;
	logic [1:0]                e_ptr, n_ptr, ptr_inc;
	logic [tcf_pkg::ADD_W-1:0] e_pend, n_pend, pend_new;
	logic [tcf_pkg::ADD_W:0]   pend_sum;
	logic [7:0]                e_thr, n_thr, put_byte;
	logic [CW-1:0]             e_cnt;
	logic                      e_done, gt, act_put, act_dec;
	logic [2:0]                dec_wid;
	logic signed [SW-1:0]      sum_in;

	logic                       accept;
	logic                       bcd_start, bcd_done;
	logic [tcf_pkg::BIN_W-1:0]  clamp_val;
	logic [tcf_pkg::BCD_W-1:0]  bcd_val;
	logic [2:0]                 sig, ndig, kdig;
	logic [CW-1:0]              room;
	logic [3:0]                 cur_nib;
	logic                       push_valid, push_ready;
	tcf_pkg::tcf_word_t         push_word;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		e_mode = first ? tcf_pkg::M_NORMAL : mode_q;
		e_a0   = first ? load_arg(row_arg) : arg0_q;
		e_a1   = first ? load_arg(column) : arg1_q;
		e_ptr  = first ? 2'd0 : ptr_q;
		e_pend = first ? '0 : pend_q;
		e_thr  = first ? 8'd0 : thr_q;
		e_cnt  = first ? '0 : cnt_q;
		e_done = (e_mode == tcf_pkg::M_DONE) || (e_cnt >= CW'(OUT_LIMIT));
		cur     = (e_ptr == 2'd0) ? e_a0 : e_a1;
		ptr_inc = (e_ptr == 2'd2) ? 2'd2 : e_ptr + 2'd1;
		a0_inc  = (e_a0 == ARG_MAX) ? e_a0 : e_a0 + AW'(1);
		a1_inc  = (e_a1 == ARG_MAX) ? e_a1 : e_a1 + AW'(1);
		gt      = cur > $signed({{(AW-8){1'b0}}, e_thr});
		pend_sum = {1'b0, e_pend} + {{(tcf_pkg::ADD_W-7){1'b0}}, cap_byte};
		pend_new = pend_sum[tcf_pkg::ADD_W] ? tcf_pkg::ADD_MAX
			: pend_sum[tcf_pkg::ADD_W-1:0];
		sum_in = $signed({cur[AW-1], cur})
			+ $signed({{(SW-tcf_pkg::ADD_W){1'b0}}, e_pend});

		n_mode   = e_mode;
		n_a0     = e_a0;
		n_a1     = e_a1;
		n_ptr    = e_ptr;
		n_pend   = e_pend;
		n_thr    = e_thr;
		act_put  = 1'b0;
		act_dec  = 1'b0;
		put_byte = cap_byte;
		dec_wid  = 3'd0;
		if (!e_done) begin
			if (cap_byte == tcf_pkg::CH_NUL) begin
				n_mode = tcf_pkg::M_DONE;
			end else begin
				unique case (e_mode)
					tcf_pkg::M_NORMAL: begin
						if (cap_byte == tcf_pkg::CH_PCT) begin
							n_mode = tcf_pkg::M_PCT;
						end else begin
							act_put = 1'b1;
						end
					end
					tcf_pkg::M_PCT: begin
						n_mode = tcf_pkg::M_NORMAL;
						unique case (cap_byte)
							tcf_pkg::CH_D, tcf_pkg::CH_TWO, tcf_pkg::CH_THREE: begin
								act_dec = 1'b1;
								n_ptr   = ptr_inc;
								n_pend  = '0;
								if (cap_byte == tcf_pkg::CH_TWO) begin
									dec_wid = 3'd2;
								end else if (cap_byte == tcf_pkg::CH_THREE) begin
									dec_wid = 3'd3;
								end
							end
							tcf_pkg::CH_DOT: begin
								act_put  = 1'b1;
								put_byte = cur[7:0] + e_pend[7:0];
								n_ptr    = ptr_inc;
								n_pend   = '0;
							end
							tcf_pkg::CH_PLUS: n_mode = tcf_pkg::M_PLUS;
							tcf_pkg::CH_I: begin
								n_a0 = a0_inc;
								n_a1 = a1_inc;
							end
							tcf_pkg::CH_R: begin
								n_a0 = e_a1;
								n_a1 = e_a0;
							end
							tcf_pkg::CH_GT: n_mode = tcf_pkg::M_GTX;
							default: act_put = 1'b1;
						endcase
					end
					tcf_pkg::M_PLUS: begin
						act_put  = 1'b1;
						put_byte = cur[7:0] + cap_byte;
						n_ptr    = ptr_inc;
						n_pend   = '0;
						n_mode   = tcf_pkg::M_NORMAL;
					end
					tcf_pkg::M_GTX: begin
						n_thr  = cap_byte;
						n_mode = tcf_pkg::M_GTY;
					end
					tcf_pkg::M_GTY: begin
						if (gt) begin
							n_pend = pend_new;
						end
						n_mode = tcf_pkg::M_NORMAL;
					end
					default: n_mode = tcf_pkg::M_DONE;
				endcase
			end
		end
		if (last) begin
			n_mode = tcf_pkg::M_DONE;
		end
	end

	// clamp to 0..99999 before conversion
	always_comb begin
		if (sum_q[SW-1]) begin
			clamp_val = '0;
		end else if (CMPW'($unsigned(sum_q)) > CMPW'(tcf_pkg::DEC_MAX)) begin
			clamp_val = tcf_pkg::DEC_MAX;
		end else begin
			clamp_val = tcf_pkg::BIN_W'($unsigned(sum_q));
		end
	end

	assign bcd_start = (state_q == S_CLAMP);

	tcf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (clamp_val),
		.done   (bcd_done),
		.bcd    (bcd_val)
	);

	// significant digits, padded width, and how many fit under the limit
	always_comb begin
		if (bcd_val[19:16] != 4'd0) begin
			sig = 3'd5;
		end else if (bcd_val[15:12] != 4'd0) begin
			sig = 3'd4;
		end else if (bcd_val[11:8] != 4'd0) begin
			sig = 3'd3;
		end else if (bcd_val[7:4] != 4'd0) begin
			sig = 3'd2;
		end else begin
			sig = 3'd1;
		end
		ndig    = (sig < wid_q) ? wid_q : sig;
		room    = CW'(OUT_LIMIT) - cnt_q;
		kdig    = (room < CW'(ndig)) ? room[2:0] : ndig;
		cur_nib = bcd_val[dig_idx_q*4 +: 4];
	end

	always_comb begin
		push_valid = 1'b0;
		push_word  = hold_q;
		if (state_q == S_EMIT) begin
			push_valid = 1'b1;
		end else if (state_q == S_DIG) begin
			push_valid     = 1'b1;
			push_word.data = tcf_pkg::CH_ZERO + {4'd0, cur_nib};
			push_word.bv   = 1'b1;
			push_word.eos  = last_q && (dig_left_q == 3'd1);
		end
	end

	tcf_oreg u_oreg (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_valid    (push_valid),
		.push_word     (push_word),
		.push_ready    (push_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= tcf_pkg::M_NORMAL;
			arg0_q     <= '0;
			arg1_q     <= '0;
			ptr_q      <= '0;
			pend_q     <= '0;
			thr_q      <= '0;
			cnt_q      <= '0;
			last_q     <= 1'b0;
			dig_idx_q  <= '0;
			dig_left_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= n_mode;
						arg0_q <= n_a0;
						arg1_q <= n_a1;
						ptr_q  <= n_ptr;
						pend_q <= n_pend;
						thr_q  <= n_thr;
						cnt_q  <= act_put ? e_cnt + CW'(1) : e_cnt;
						last_q <= last;
						if (act_put) begin
							state_q <= S_EMIT;
						end else if (act_dec) begin
							state_q <= S_CLAMP;
						end else if (last) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (push_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_CLAMP: state_q <= S_CONV;
				S_CONV: begin
					if (bcd_done) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					dig_idx_q  <= ndig - 3'd1;
					dig_left_q <= kdig;
					if (kdig != 3'd0) begin
						state_q <= S_DIG;
					end else if (last_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIG: begin
					if (push_ready) begin
						cnt_q      <= cnt_q + CW'(1);
						dig_idx_q  <= dig_idx_q - 3'd1;
						dig_left_q <= dig_left_q - 3'd1;
						if (dig_left_q == 3'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold word for single-byte results and the bare end marker, plus the decimal sum and width
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= sum_in;
			wid_q <= dec_wid;
			hold_q.data <= act_put ? put_byte : tcf_pkg::CH_NUL;
			hold_q.bv   <= act_put;
			hold_q.eos  <= last;
		end else if (state_q == S_PREP) begin
			hold_q.data <= tcf_pkg::CH_NUL;
			hold_q.bv   <= 1'b0;
			hold_q.eos  <= 1'b1;
		end
	end

endmodule

// ----- rtl/core/tcf_chk.sv -----
// Port-level checker for the formatter core, bound to the formatter core module.
module tcf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        end_of_string
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(byte_valid) && $stable(end_of_string))
		else $error("output word changed while stalled");

	// a word without a character is only ever the end marker
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> end_of_string && (out_byte == 8'h00))
		else $error("bare word is not a clean end marker");

	// an open input stays open until a word arrives
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input closed with no word taken");

	// reset leaves no word pending and the input open
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_ready)
		else $error("state not clear after reset");

endmodule

bind termcap_cursor_formatter_core tcf_chk u_tcf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_byte      (out_byte),
	.byte_valid    (byte_valid),
	.end_of_string (end_of_string)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the formatter core: capability strings in, checked words out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OUT_LIMIT    = 31;
	localparam int ARG_BITS     = 16;
	localparam int ARG_HI       = (1 << (ARG_BITS + 1)) - 1;
	localparam int ARG_LO       = -ARG_HI - 1;
	localparam int RAND_ITEMS   = 170;
	localparam int MAX_GAP      = 17;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_LONG    = 400;
	localparam int QUIET_TAIL   = 40;
	localparam int END_TAIL     = 60;
	localparam int LIMIT_CYCLES = 300000;
	localparam int MAX_SHOWN    = 10;

	typedef struct {
		logic [7:0]        cap;
		logic              first;
		logic              last;
		logic signed [15:0] col;
		logic signed [15:0] row;
		bit                drain;
	} cap_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        cap_byte = 8'h00;
	logic              first = 1'b0;
	logic              last = 1'b0;
	logic signed [15:0] column = 16'sd0;
	logic signed [15:0] row_arg = 16'sd0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_byte;
	logic              byte_valid;
	logic              end_of_string;

	termcap_cursor_formatter_core #(
		.OUT_LIMIT(OUT_LIMIT),
		.ARG_BITS (ARG_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cap_byte     (cap_byte),
		.first        (first),
		.last         (last),
		.column       (column),
		.row_arg      (row_arg),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.end_of_string(end_of_string)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// formatter state mirror
	logic [tcf_pkg::MODE_W-1:0] fmt_mode;
	logic signed [ARG_BITS+1:0] fmt_arg0;
	logic signed [ARG_BITS+1:0] fmt_arg1;
	logic [1:0]                fmt_ptr;
	logic [tcf_pkg::ADD_W-1:0] fmt_add;
	logic [7:0]                fmt_thr;
	logic [4:0]                fmt_cnt;

	tcf_pkg::tcf_word_t step_words[$];
	tcf_pkg::tcf_word_t want_words[$];
	cap_item_t          cap_items_q[$];
	logic [7:0]         str_buf[$];

	int  items_taken = 0;
	int  total_items = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  quiet_cycles = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;
	bit  long_hold_done = 1'b0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;

	function void clear_formatter();
		fmt_mode = tcf_pkg::M_NORMAL;
		fmt_arg0 = '0;
		fmt_arg1 = '0;
		fmt_ptr  = '0;
		fmt_add  = '0;
		fmt_thr  = '0;
		fmt_cnt  = '0;
	endfunction

	function automatic logic signed [ARG_BITS+1:0] clamp_arg(int v);
		if (v > ARG_HI) v = ARG_HI;
		if (v < ARG_LO) v = ARG_LO;
		return v[ARG_BITS+1:0];
	endfunction

	function int cur_arg();
		if (fmt_ptr == 2'd0)
			return int'(fmt_arg0);
		return int'(fmt_arg1);
	endfunction

	function void advance_arg();
		if (fmt_ptr < 2'd2)
			fmt_ptr = fmt_ptr + 2'd1;
		fmt_add = '0;
	endfunction

	function void emit(logic [7:0] b);
		tcf_pkg::tcf_word_t w;
		if (fmt_cnt < OUT_LIMIT && step_words.size() < tcf_pkg::NDIG) begin
			w.data = b;
			w.bv   = 1'b1;
			w.eos  = 1'b0;
			step_words.push_back(w);
			fmt_cnt = fmt_cnt + 5'd1;
		end
	endfunction

	function void emit_decimal(int width);
		int         v;
		int         n;
		logic [7:0] dig[tcf_pkg::NDIG];
		v = cur_arg() + int'(fmt_add);
		advance_arg();
		if (v < 0) v = 0;
		if (v > int'(tcf_pkg::DEC_MAX)) v = int'(tcf_pkg::DEC_MAX);
		n = 0;
		do begin
			dig[n] = tcf_pkg::CH_ZERO + 8'(v % 10);
			v = v / 10;
			n++;
		end while (v != 0 && n < tcf_pkg::NDIG);
		while (n < width && n < tcf_pkg::NDIG) begin
			dig[n] = tcf_pkg::CH_ZERO;
			n++;
		end
		while (n > 0) begin
			n--;
			emit(dig[n]);
		end
	endfunction

	function void parse_cap(logic [7:0] b);
		int v;
		if (fmt_mode == tcf_pkg::M_DONE) return;
		if (b == tcf_pkg::CH_NUL) begin
			fmt_mode = tcf_pkg::M_DONE;
			return;
		end
		case (fmt_mode)
			tcf_pkg::M_NORMAL: begin
				if (b == tcf_pkg::CH_PCT) fmt_mode = tcf_pkg::M_PCT;
				else emit(b);
			end
			tcf_pkg::M_PCT: begin
				fmt_mode = tcf_pkg::M_NORMAL;
				case (b)
					tcf_pkg::CH_D:     emit_decimal(0);
					tcf_pkg::CH_TWO:   emit_decimal(2);
					tcf_pkg::CH_THREE: emit_decimal(3);
					tcf_pkg::CH_DOT: begin
						v = cur_arg() + int'(fmt_add);
						advance_arg();
						emit(v[7:0]);
					end
					tcf_pkg::CH_PLUS: fmt_mode = tcf_pkg::M_PLUS;
					tcf_pkg::CH_I: begin
						fmt_arg0 = clamp_arg(int'(fmt_arg0) + 1);
						fmt_arg1 = clamp_arg(int'(fmt_arg1) + 1);
					end
					tcf_pkg::CH_R: {fmt_arg0, fmt_arg1} = {fmt_arg1, fmt_arg0};
					tcf_pkg::CH_GT: fmt_mode = tcf_pkg::M_GTX;
					default: emit(b);
				endcase
			end
			tcf_pkg::M_PLUS: begin
				// pending add is dropped here, not applied
				v = cur_arg() + int'(b);
				advance_arg();
				emit(v[7:0]);
				fmt_mode = tcf_pkg::M_NORMAL;
			end
			tcf_pkg::M_GTX: begin
				fmt_thr  = b;
				fmt_mode = tcf_pkg::M_GTY;
			end
			tcf_pkg::M_GTY: begin
				if (cur_arg() > int'(fmt_thr)) begin
					v = int'(fmt_add) + int'(b);
					fmt_add = (v > int'(tcf_pkg::ADD_MAX)) ? tcf_pkg::ADD_MAX
						: v[tcf_pkg::ADD_W-1:0];
				end
				fmt_mode = tcf_pkg::M_NORMAL;
			end
			default: fmt_mode = tcf_pkg::M_DONE;
		endcase
		if (fmt_cnt >= OUT_LIMIT) fmt_mode = tcf_pkg::M_DONE;
	endfunction

	function void format_byte(logic [7:0] b, logic is_first, logic is_last,
			logic signed [15:0] col, logic signed [15:0] row);
		tcf_pkg::tcf_word_t w;
		if (is_first) begin
			clear_formatter();
			fmt_arg0 = clamp_arg(int'(row));
			fmt_arg1 = clamp_arg(int'(col));
		end
		step_words.delete();
		parse_cap(b);
		if (is_last) begin
			if (step_words.size() == 0) begin
				// bare end marker
				w.data = 8'h00;
				w.bv   = 1'b0;
				w.eos  = 1'b1;
			end else begin
				w = step_words.pop_back();
				w.eos = 1'b1;
			end
			step_words.push_back(w);
			fmt_mode = tcf_pkg::M_DONE;
		end
		foreach (step_words[k])
			want_words.push_back(step_words[k]);
	endfunction

	function void push_cap(logic [7:0] b, logic is_first, logic is_last,
			logic signed [15:0] col, logic signed [15:0] row, bit drain);
		cap_item_t it;
		it.cap   = b;
		it.first = is_first;
		it.last  = is_last;
		it.col   = col;
		it.row   = row;
		it.drain = drain;
		cap_items_q.push_back(it);
	endfunction

	function void add_string(logic signed [15:0] col, logic signed [15:0] row, bit drain);
		foreach (str_buf[i])
			push_cap(str_buf[i], i == 0, i == str_buf.size() - 1, col, row, drain && i == 0);
	endfunction

	function automatic logic signed [15:0] pick_arg();
		int v;
		case ($urandom_range(0, 3))
			0:       v = $urandom_range(0, 120);
			1:       v = -int'($urandom_range(1, 300));
			2:       v = $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0:       v = 32767;
					1:       v = -32768;
					2:       v = -1;
					default: v = 0;
				endcase
			end
		endcase
		return v[15:0];
	endfunction

	function void add_token(bit dec_only);
		int k;
		k = dec_only ? $urandom_range(3, 5) : $urandom_range(0, 13);
		if (dec_only && $urandom_range(0, 5) == 0) k = 10;
		case (k)
			0, 1, 2: str_buf.push_back(8'($urandom_range(1, 255)));
			3: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_D);
			end
			4: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_TWO);
			end
			5: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_THREE);
			end
			6: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_DOT);
			end
			7: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_PLUS);
				str_buf.push_back(8'($urandom_range(1, 255)));
			end
			8: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_I);
			end
			9: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_R);
			end
			10: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_GT);
				if ($urandom_range(0, 1) == 0)
					str_buf.push_back(8'($urandom_range(1, 60)));
				else
					str_buf.push_back(8'($urandom_range(1, 255)));
				str_buf.push_back(8'($urandom_range(1, 255)));
			end
			11: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(tcf_pkg::CH_PCT);
			end
			12: begin
				str_buf.push_back(tcf_pkg::CH_PCT);
				str_buf.push_back(8'($urandom_range(1, 255)));
			end
			default: str_buf.push_back(tcf_pkg::CH_NUL);
		endcase
	endfunction

	task build_stimulus();
		int added;
		int ntok;
		bit heavy;
		bit mid_drained;
		// %2 with largest row, %d with most negative column
		str_buf = {tcf_pkg::CH_PCT, tcf_pkg::CH_TWO, tcf_pkg::CH_PCT, tcf_pkg::CH_D};
		add_string(-16'sd32768, 16'sd32767, 1'b0);
		// swap, conditional add, padded decimal, raw byte of -1
		str_buf = {tcf_pkg::CH_PCT, tcf_pkg::CH_R, tcf_pkg::CH_PCT, tcf_pkg::CH_GT,
			8'h01, 8'hff, tcf_pkg::CH_PCT, tcf_pkg::CH_THREE,
			tcf_pkg::CH_PCT, tcf_pkg::CH_DOT};
		add_string(16'sd100, -16'sd1, 1'b0);
		// increment, plus offset, literal percent, unknown code
		str_buf = {tcf_pkg::CH_PCT, tcf_pkg::CH_I, tcf_pkg::CH_PCT, tcf_pkg::CH_PLUS,
			8'hff, tcf_pkg::CH_PCT, tcf_pkg::CH_PCT, tcf_pkg::CH_PCT, 8'h71};
		add_string(16'sd32767, -16'sd32768, 1'b0);
		// zero byte ends the string early
		str_buf = {8'h78, tcf_pkg::CH_NUL, 8'h79};
		add_string(16'sd5, 16'sd7, 1'b0);
		// code cut off by the last byte, then stray bytes with no first
		str_buf = {8'h61, tcf_pkg::CH_PCT};
		add_string(16'sd3, 16'sd4, 1'b0);
		push_cap(8'h7a, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0);
		push_cap(8'h7a, 1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0);

		added = 0;
		mid_drained = 1'b0;
		while (added < RAND_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				push_cap(8'($urandom), 1'($urandom), 1'($urandom), pick_arg(), pick_arg(), 1'b0);
				added++;
			end else begin
				heavy = ($urandom_range(0, 4) == 0);
				ntok = heavy ? $urandom_range(6, 10) : $urandom_range(1, 8);
				str_buf.delete();
				repeat (ntok) add_token(heavy);
				if (str_buf.size() > 1 && $urandom_range(0, 7) == 0)
					void'(str_buf.pop_back());
				add_string(pick_arg(), pick_arg(),
					added == 0 || (!mid_drained && added >= RAND_ITEMS / 2));
				if (added >= RAND_ITEMS / 2) mid_drained = 1'b1;
				added += str_buf.size();
			end
		end
	endtask

	// sender: words change on the falling edge
	always @(negedge clk) begin
		logic      v_next;
		cap_item_t it;
		v_next = in_valid;
		quiet_cycles = (want_words.size() == 0) ? quiet_cycles + 1 : 0;
		if (arst_n) begin
			if (in_valid && in_taken) v_next = 1'b0;
			if (!v_next) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (cap_items_q.size() > 0 &&
						(!cap_items_q[0].drain || quiet_cycles >= QUIET_TAIL)) begin
					it = cap_items_q.pop_front();
					cap_byte <= it.cap;
					first    <= it.first;
					last     <= it.last;
					column   <= it.col;
					row_arg  <= it.row;
					v_next = 1'b1;
					if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
					tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
				end
			end
		end
		in_valid <= v_next;
	end

	// receiver: per-word stall, plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_taken) begin
				if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
				rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (!long_hold_done && items_taken >= HOLD_AT) begin
				long_hold_done = 1'b1;
				rx_gap = HOLD_LONG;
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check output words, then predict from the accepted input word
	always @(posedge clk) begin
		tcf_pkg::tcf_word_t want;
		if (arst_n) begin
			in_taken  <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				if (want_words.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected word: byte %02h bv %0b eos %0b",
							out_byte, byte_valid, end_of_string);
				end else begin
					want = want_words.pop_front();
					if (out_byte !== want.data || byte_valid !== want.bv ||
							end_of_string !== want.eos) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display({"mismatch: got byte %02h bv %0b eos %0b,",
								" want byte %02h bv %0b eos %0b"},
								out_byte, byte_valid, end_of_string,
								want.data, want.bv, want.eos);
					end
				end
			end
			if (in_valid && in_ready) begin
				format_byte(cap_byte, first, last, column, row_arg);
				items_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		clear_formatter();
		build_stimulus();
		total_items = cap_items_q.size();
		// falling edge on reset once every process is waiting
		arst_n <= 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		while (items_taken < total_items) @(posedge clk);
		while (want_words.size() != 0) @(posedge clk);
		repeat (END_TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tcf_pkg.sv
rtl/core/tcf_bcd.sv
rtl/core/tcf_oreg.sv
rtl/core/termcap_cursor_formatter_core.sv
rtl/core/tcf_chk.sv
tb/tb_top.sv
